FILE: src/uep0_pkg.sv
// ----------------------------------------------------------------------------
// uep0_pkg
// Shared types and codes for the endpoint-zero control engine.
// ----------------------------------------------------------------------------
package uep0_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CMD_SETUP = 2'd0;
	localparam logic [1:0] CMD_IN    = 2'd1;
	localparam logic [1:0] CMD_OUT   = 2'd2;
	localparam logic [1:0] CMD_RESET = 2'd3;

	localparam logic [1:0] HS_NAK   = 2'd0;
	localparam logic [1:0] HS_VALID = 2'd1;
	localparam logic [1:0] HS_STALL = 2'd2;
	localparam logic [1:0] HS_KEEP  = 2'd3;

	localparam logic [1:0] TG_ZERO = 2'd0;
	localparam logic [1:0] TG_ONE  = 2'd1;
	localparam logic [1:0] TG_KEEP = 2'd2;

	localparam logic [2:0] SRC_NONE   = 3'd0;
	localparam logic [2:0] SRC_DEVICE = 3'd1;
	localparam logic [2:0] SRC_CONFIG = 3'd2;
	localparam logic [2:0] SRC_STRING = 3'd3;
	localparam logic [2:0] SRC_CFGVAL = 3'd4;
	localparam logic [2:0] SRC_STATUS = 3'd5;

	localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
	localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'd7;
	localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
	localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;
	localparam logic [7:0] REQ_SET_INTERFACE  = 8'd11;

	localparam logic [2:0] REG_DEVICE_LEN = 3'd0;
	localparam logic [2:0] REG_CONFIG_LEN = 3'd1;
	localparam logic [2:0] REG_WAKEUP     = 3'd2;
	localparam logic [2:0] REG_MAX_PACKET = 3'd3;
	localparam logic [2:0] REG_STRINGS    = 3'd4;

	// classified event handed from front to back
	typedef struct packed {
		logic [1:0] cmd;
		logic       stall;
		logic [7:0] code;
		logic [2:0] src;
		logic [2:0] str;
		logic [7:0] total;
		logic [6:0] address;
		logic [7:0] cfg_value;
	} event_t;

	typedef struct packed {
		logic [1:0] tx_handshake;
		logic [1:0] rx_handshake;
		logic [1:0] tx_toggle;
		logic [1:0] rx_toggle;
		logic [2:0] data_source;
		logic [2:0] string_select;
		logic [7:0] data_offset;
		logic [6:0] data_count;
		logic       address_write;
		logic [6:0] address_value;
		logic       configured;
		logic [7:0] config_value;
	} result_t;

endpackage

FILE: src/uep0_front.sv
// ----------------------------------------------------------------------------
// uep0_front
// Accepts events and decodes standard requests into classified events.
// ----------------------------------------------------------------------------
module uep0_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	input  logic [7:0]        request_type,
	input  logic [7:0]        request_code,
	input  logic [7:0]        value_low,
	input  logic [7:0]        value_high,
	input  logic [15:0]       index_word,
	input  logic [15:0]       length_word,
	input  logic [7:0]        device_len,
	input  logic [7:0]        config_len,
	input  logic              wakeup_ok,
	input  logic [47:0]       string_lens,
	output logic              ev_valid,
	input  logic              ev_ready,
	output uep0_pkg::event_t  ev
);
	import uep0_pkg::*;

	event_t ev_s1;
	logic   valid_s1;
	event_t dec;
	logic   feat_ok;
	logic [7:0] ep;
	logic [7:0] len;
	logic [2:0] str;

	assign in_ready = !valid_s1 || ev_ready;
	assign ev_valid = valid_s1;
	assign ev = ev_s1;

	always_comb begin
		ep = index_word[7:0];
		feat_ok = 1'b0;
		if (request_type[4:0] == 5'd0) begin
			feat_ok = (value_low == 8'd1) && wakeup_ok;
		end else if (request_type[4:0] == 5'd2) begin
			feat_ok = ep == 8'h01 || ep == 8'h81 || ep == 8'h02 ||
				ep == 8'h82 || ep == 8'h03 || ep == 8'h83;
		end
		str = (value_low <= 8'd5) ? value_low[2:0] : 3'd3;
		len = 8'd0;
		dec = '0;
		dec.cmd = command;
		dec.code = request_code;
		dec.address = value_low[6:0];
		dec.cfg_value = value_low;
		if (request_type[6:5] != 2'd0) begin
			dec.stall = 1'b1;
		end else begin
			case (request_code)
				REQ_GET_DESCRIPTOR: begin
					if (value_high == 8'd1) begin
						dec.src = SRC_DEVICE;
						len = device_len;
					end else if (value_high == 8'd2) begin
						dec.src = SRC_CONFIG;
						len = config_len;
					end else if (value_high == 8'd3) begin
						dec.src = SRC_STRING;
						dec.str = str;
						len = string_lens[{str, 3'b000} +: 8];
					end else begin
						dec.stall = 1'b1;
					end
				end
				REQ_GET_CONFIG: begin
					dec.src = SRC_CFGVAL;
					len = 8'd1;
				end
				REQ_GET_STATUS: begin
					dec.src = SRC_STATUS;
					len = 8'd2;
				end
				REQ_CLEAR_FEATURE, REQ_SET_FEATURE: dec.stall = !feat_ok;
				REQ_SET_ADDRESS, REQ_SET_CONFIG, REQ_SET_DESCRIPTOR,
				REQ_GET_INTERFACE, REQ_SET_INTERFACE: ;
				default: dec.stall = 1'b1;
			endcase
		end
		dec.total = ({8'd0, len} < length_word) ? len : length_word[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ev_s1 <= dec;
		end
	end

endmodule

FILE: src/uep0_queue.sv
// ----------------------------------------------------------------------------
// uep0_queue
// Small FIFO between the decode front and the execution back.
// ----------------------------------------------------------------------------
module uep0_queue #(
	parameter int DEPTH = uep0_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  uep0_pkg::event_t  wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output uep0_pkg::event_t  rd_data
);
	import uep0_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	event_t         mem_q [DEPTH];
	logic [AW-1:0]  wp_q;
	logic [AW-1:0]  rp_q;
	logic [AW:0]    cnt_q;
	logic           push;
	logic           pop;

	assign wr_ready = cnt_q != DEPTH[AW:0];
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH[AW:0]) else $error("queue count overflow");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("queue pop count");
	a_push_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue push count");

endmodule

FILE: src/uep0_back.sv
// ----------------------------------------------------------------------------
// uep0_back
// Executes classified events against the transfer state, registers results.
// ----------------------------------------------------------------------------
module uep0_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ev_valid,
	output logic              ev_ready,
	input  uep0_pkg::event_t  ev,
	input  logic [6:0]        max_packet,
	output logic              res_valid,
	input  logic              res_ready,
	output uep0_pkg::result_t res
);
	import uep0_pkg::*;

	logic [7:0] req_q;
	logic [2:0] src_q;
	logic [2:0] str_q;
	logic [7:0] remain_q;
	logic [7:0] offset_q;
	logic       toggle_q;
	logic [6:0] paddr_q;
	logic [7:0] cfg_q;
	logic       enum_q;
	logic       valid_q;
	result_t    res_q;
	result_t    r;
	logic [7:0] mp;
	logic [7:0] chunk;
	logic       take;

	assign ev_ready = !valid_q || res_ready;
	assign take = ev_valid && ev_ready;
	assign res_valid = valid_q;
	assign res = res_q;

	always_comb begin
		if (max_packet < 7'd8) begin
			mp = 8'd8;
		end else if (max_packet > 7'd64) begin
			mp = 8'd64;
		end else begin
			mp = {1'b0, max_packet};
		end
		if (ev.cmd == CMD_SETUP) begin
			chunk = (ev.total > mp) ? mp : ev.total;
		end else begin
			chunk = (remain_q > mp) ? mp : remain_q;
		end
		r = '0;
		r.tx_handshake = HS_KEEP;
		r.rx_handshake = HS_KEEP;
		r.tx_toggle = TG_KEEP;
		r.rx_toggle = TG_KEEP;
		case (ev.cmd)
			CMD_SETUP: begin
				if (ev.stall) begin
					r.tx_handshake = HS_STALL;
					r.rx_handshake = HS_STALL;
				end else begin
					r.tx_handshake = HS_VALID;
					r.rx_handshake = HS_VALID;
					r.tx_toggle = TG_ONE;
					r.rx_toggle = TG_ONE;
					if (ev.src != SRC_NONE) begin
						r.data_source = ev.src;
						r.string_select = (ev.src == SRC_STRING) ? ev.str : 3'd0;
						r.data_count = chunk[6:0];
					end
				end
			end
			CMD_IN: begin
				if (req_q == REQ_GET_DESCRIPTOR && remain_q != 8'd0) begin
					r.rx_handshake = HS_NAK;
					r.tx_handshake = HS_VALID;
					r.tx_toggle = {1'b0, ~toggle_q};
					if (src_q != SRC_NONE) begin
						r.data_source = src_q;
						r.string_select = (src_q == SRC_STRING) ? str_q : 3'd0;
						r.data_offset = offset_q;
						r.data_count = chunk[6:0];
					end
				end else begin
					if (req_q == REQ_SET_ADDRESS) begin
						r.address_write = 1'b1;
						r.address_value = paddr_q;
					end
					r.rx_handshake = HS_VALID;
					r.tx_handshake = HS_NAK;
					r.rx_toggle = TG_ONE;
				end
			end
			CMD_OUT: begin
				r.tx_handshake = HS_VALID;
				r.rx_handshake = HS_VALID;
				r.tx_toggle = TG_ONE;
				r.rx_toggle = TG_ONE;
			end
			default: begin
				r.address_write = 1'b1;
				r.tx_handshake = HS_NAK;
				r.rx_handshake = HS_VALID;
				r.tx_toggle = TG_ZERO;
				r.rx_toggle = TG_ZERO;
			end
		endcase
		r.configured = enum_q;
		r.config_value = cfg_q;
		if (ev.cmd == CMD_SETUP && !ev.stall && ev.code == REQ_SET_CONFIG) begin
			r.configured = 1'b1;
			r.config_value = ev.cfg_value;
		end
		if (ev.cmd == CMD_RESET) begin
			r.configured = 1'b0;
			r.config_value = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
			src_q <= '0;
			str_q <= '0;
			remain_q <= '0;
			offset_q <= '0;
			toggle_q <= 1'b1;
			paddr_q <= '0;
			cfg_q <= '0;
			enum_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (res_ready || !valid_q) begin
				valid_q <= ev_valid;
			end
			if (take) begin
				case (ev.cmd)
					CMD_SETUP: begin
						toggle_q <= 1'b1;
						req_q <= ev.code;
						if (ev.stall) begin
							src_q <= '0;
							str_q <= '0;
							remain_q <= '0;
							offset_q <= '0;
						end else begin
							src_q <= ev.src;
							str_q <= ev.str;
							remain_q <= ev.total - chunk;
							offset_q <= chunk;
							if (ev.code == REQ_SET_ADDRESS) begin
								paddr_q <= ev.address;
							end
							if (ev.code == REQ_SET_CONFIG) begin
								cfg_q <= ev.cfg_value;
								enum_q <= 1'b1;
							end
						end
					end
					CMD_IN: begin
						if (req_q == REQ_GET_DESCRIPTOR && remain_q != 8'd0) begin
							toggle_q <= ~toggle_q;
							offset_q <= offset_q + chunk;
							remain_q <= remain_q - chunk;
						end else if (req_q == REQ_SET_ADDRESS) begin
							paddr_q <= '0;
						end
					end
					CMD_OUT: ;
					default: begin
						req_q <= '0;
						src_q <= '0;
						str_q <= '0;
						remain_q <= '0;
						offset_q <= '0;
						toggle_q <= 1'b1;
						paddr_q <= '0;
						cfg_q <= '0;
						enum_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= r;
		end
	end

	a_chunk_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.data_count <= 7'd64) else $error("chunk exceeds packet");
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.address_write) |-> res.address_value == 7'd0)
		else $error("address value without write");
	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(take && ev.cmd == CMD_RESET) |=> (!enum_q && remain_q == 8'd0))
		else $error("bus reset left state");

endmodule

FILE: src/usb_ep0_control_handler_unit.sv
// ----------------------------------------------------------------------------
// usb_ep0_control_handler_unit
// Endpoint-zero control engine, top level.
// ----------------------------------------------------------------------------
// Each accepted event (setup, IN done, OUT done, bus reset) yields one result
// giving handshake states, toggles and the next data chunk. An event passes a
// decode register, a two-entry queue and an execute register before its
// result appears; one event per cycle is sustained while the output is taken.
// Configuration writes take effect at once and should be made while no event
// is in flight.
module usb_ep0_control_handler_unit #(
	parameter int QUEUE_DEPTH = uep0_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request_code,
	input  logic [7:0]  value_low,
	input  logic [7:0]  value_high,
	input  logic [15:0] index_word,
	input  logic [15:0] length_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  tx_handshake,
	output logic [1:0]  rx_handshake,
	output logic [1:0]  tx_toggle,
	output logic [1:0]  rx_toggle,
	output logic [2:0]  data_source,
	output logic [2:0]  string_select,
	output logic [7:0]  data_offset,
	output logic [6:0]  data_count,
	output logic        address_write,
	output logic [6:0]  address_value,
	output logic        configured,
	output logic [7:0]  config_value
);
	import uep0_pkg::*;

	logic [7:0]  dev_len_q;
	logic [7:0]  cfg_len_q;
	logic        wakeup_q;
	logic [6:0]  max_pkt_q;
	logic [47:0] str_len_q;
	event_t      f_ev;
	logic        f_valid;
	logic        f_ready;
	event_t      q_ev;
	logic        q_valid;
	logic        q_ready;
	result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_len_q <= 8'd18;
			cfg_len_q <= 8'd32;
			wakeup_q <= 1'b0;
			max_pkt_q <= 7'd64;
			str_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEVICE_LEN: dev_len_q <= cfg_data[7:0];
				REG_CONFIG_LEN: cfg_len_q <= cfg_data[7:0];
				REG_WAKEUP:     wakeup_q <= cfg_data[0];
				REG_MAX_PACKET: max_pkt_q <= cfg_data[6:0];
				REG_STRINGS:    str_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	uep0_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .request_type(request_type),
		.request_code(request_code), .value_low(value_low),
		.value_high(value_high), .index_word(index_word),
		.length_word(length_word),
		.device_len(dev_len_q), .config_len(cfg_len_q),
		.wakeup_ok(wakeup_q), .string_lens(str_len_q),
		.ev_valid(f_valid), .ev_ready(f_ready), .ev(f_ev)
	);

	uep0_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_ev),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_ev)
	);

	uep0_back u_back (
		.clk(clk), .arst_n(arst_n),
		.ev_valid(q_valid), .ev_ready(q_ready), .ev(q_ev),
		.max_packet(max_pkt_q),
		.res_valid(out_valid), .res_ready(out_ready), .res(res)
	);

	assign tx_handshake = res.tx_handshake;
	assign rx_handshake = res.rx_handshake;
	assign tx_toggle = res.tx_toggle;
	assign rx_toggle = res.rx_toggle;
	assign data_source = res.data_source;
	assign string_select = res.string_select;
	assign data_offset = res.data_offset;
	assign data_count = res.data_count;
	assign address_write = res.address_write;
	assign address_value = res.address_value;
	assign configured = res.configured;
	assign config_value = res.config_value;

endmodule
